// ===== rtl/als_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// als_pkg
// Shared types and constants of the addressable LED serializer.
// ----------------------------------------------------------------------------
package als_pkg;

  localparam int ColourW = 24;
  localparam int TicksW  = 8;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Classified operations between front and back.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_REJECT = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ONE_HIGH  = 2'd0;
  localparam logic [1:0] CFG_ONE_LOW   = 2'd1;
  localparam logic [1:0] CFG_ZERO_HIGH = 2'd2;
  localparam logic [1:0] CFG_ZERO_LOW  = 2'd3;

  localparam logic [TicksW-1:0] ONE_HIGH_RST  = 8'd30;
  localparam logic [TicksW-1:0] ONE_LOW_RST   = 8'd26;
  localparam logic [TicksW-1:0] ZERO_HIGH_RST = 8'd11;
  localparam logic [TicksW-1:0] ZERO_LOW_RST  = 8'd43;

  localparam logic [4:0] LAST_BIT = 5'd23;

  typedef struct packed {
    logic [1:0]         op;
    logic [7:0]         slot;
    logic [ColourW-1:0] grb;
  } als_cmd_t;

  typedef struct packed {
    logic line_level;
    logic sending;
    logic frame_done;
    logic request_error;
  } als_res_t;

endpackage
`default_nettype wire

// ===== rtl/addressable_led_serializer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// addressable_led_serializer
// One-wire LED frame driver with a per-LED colour store and timed pulses.
// Throughput: one request beat per clock unless a full queue holds it back.
// A beat is registered in the command queue and then in the result queue.
// Two-entry queues sit between the input, the engine and the result side.
// Reset is synchronous: the colour store reads as zero, pulse lengths take their
// defaults, the queues empty and no frame is in progress. No clearing pass.
// ----------------------------------------------------------------------------
module addressable_led_serializer #(
  parameter int LED_COUNT = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_idx,
  input  wire logic [7:0] cfg_data,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] in_req_type,
  input  wire logic [7:0] in_led_slot,
  input  wire logic [7:0] in_red_level,
  input  wire logic [7:0] in_green_level,
  input  wire logic [7:0] in_blue_level,
  output logic            empty,
  input  wire logic       pop,
  output logic            out_line_level,
  output logic            out_sending,
  output logic            out_frame_done,
  output logic            out_request_error
);

  import als_pkg::*;

  als_cmd_t cmd;
  logic     cmd_empty;
  logic     cmd_pop;
  als_res_t res;
  als_res_t res_q;
  logic     res_push;
  logic     res_full;

  als_front #(
    .LED_COUNT (LED_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_req_type    (in_req_type),
    .in_led_slot    (in_led_slot),
    .in_red_level   (in_red_level),
    .in_green_level (in_green_level),
    .in_blue_level  (in_blue_level),
    .cmd_pop        (cmd_pop),
    .cmd            (cmd),
    .cmd_empty      (cmd_empty)
  );

  als_back #(
    .LED_COUNT (LED_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  als_fifo #(
    .WIDTH ($bits(als_res_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign out_line_level    = res_q.line_level;
  assign out_sending       = res_q.sending;
  assign out_frame_done    = res_q.frame_done;
  assign out_request_error = res_q.request_error;

endmodule
`default_nettype wire

// ===== rtl/als_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// als_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module als_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/als_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// als_fifo
// Small register queue with full and empty flags.
// ----------------------------------------------------------------------------
module als_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/als_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// als_front
// Accepts request beats, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module als_front #(
  parameter int LED_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [1:0]        in_req_type,
  input  wire logic [7:0]        in_led_slot,
  input  wire logic [7:0]        in_red_level,
  input  wire logic [7:0]        in_green_level,
  input  wire logic [7:0]        in_blue_level,
  input  wire logic              cmd_pop,
  output als_pkg::als_cmd_t      cmd,
  output logic                   cmd_empty
);

  import als_pkg::*;

  als_cmd_t cls;
  logic     slot_bad;

  assign slot_bad = ({1'b0, in_led_slot} >= 9'(LED_COUNT));

  always_comb begin
    cls.slot = in_led_slot;
    cls.grb  = {in_green_level, in_red_level, in_blue_level};
    unique case (in_req_type)
      REQ_WRITE: cls.op = slot_bad ? OP_REJECT : OP_WRITE;
      REQ_START: cls.op = OP_START;
      REQ_TICK:  cls.op = OP_TICK;
      default:   cls.op = OP_REJECT;
    endcase
  end

  als_fifo #(
    .WIDTH ($bits(als_cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cls),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

endmodule
`default_nettype wire

// ===== rtl/als_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// als_back
// Frame engine: colour store, pulse timing and one result per command.
// ----------------------------------------------------------------------------
module als_back #(
  parameter int LED_COUNT = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_idx,
  input  wire logic [7:0]        cfg_data,
  input  wire als_pkg::als_cmd_t cmd,
  input  wire logic              cmd_empty,
  output logic                   cmd_pop,
  input  wire logic              res_full,
  output logic                   res_push,
  output als_pkg::als_res_t      res
);

  import als_pkg::*;

  localparam int AW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;

  logic [TicksW-1:0]  one_high_r, one_low_r, zero_high_r, zero_low_r;
  logic               busy_r, busy_nxt;
  logic [AW-1:0]      led_r, led_nxt;
  logic [4:0]         bit_r, bit_nxt;
  logic               high_r, high_nxt;
  logic [TicksW-1:0]  ph_r, ph_nxt;
  logic [ColourW-1:0] word_r, word_nxt;
  logic [ColourW-1:0] word0_r;
  logic [LED_COUNT-1:0] vld_r;
  logic               rd_vld_r;
  logic [ColourW-1:0] rd_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               is_last;
  logic               wr_en;
  logic               cur_bit;
  logic [TicksW-1:0]  len;
  logic [TicksW:0]    ph_inc;

  assign cmd_pop  = !cmd_empty && !res_full;
  assign res_push = cmd_pop;
  assign wr_addr  = cmd.slot[AW-1:0];
  assign wr_en    = cmd_pop && !busy_r && (cmd.op == OP_WRITE);
  assign is_last  = ({1'b0, led_r} == (AW + 1)'(LED_COUNT - 1));
  assign rd_addr  = is_last ? '0 : led_r + 1'b1;
  assign cur_bit  = word_r[ColourW-1];
  assign ph_inc   = {1'b0, ph_r} + 1'b1;

  always_comb begin
    if (high_r) begin
      len = cur_bit ? one_high_r : zero_high_r;
    end else begin
      len = cur_bit ? one_low_r : zero_low_r;
    end
  end

  als_ram #(
    .WIDTH (ColourW),
    .DEPTH (LED_COUNT),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (cmd.grb),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    busy_nxt          = busy_r;
    led_nxt           = led_r;
    bit_nxt           = bit_r;
    high_nxt          = high_r;
    ph_nxt            = ph_r;
    word_nxt          = word_r;
    res.line_level    = 1'b0;
    res.sending       = 1'b0;
    res.frame_done    = 1'b0;
    res.request_error = 1'b0;
    if (cmd_pop) begin
      if (busy_r && (cmd.op != OP_TICK)) begin
        res.line_level    = high_r;
        res.sending       = 1'b1;
        res.request_error = 1'b1;
      end else begin
        unique case (cmd.op)
          OP_WRITE: begin
          end
          OP_REJECT: begin
            res.request_error = 1'b1;
          end
          OP_START: begin
            busy_nxt       = 1'b1;
            led_nxt        = '0;
            bit_nxt        = '0;
            high_nxt       = 1'b1;
            ph_nxt         = '0;
            word_nxt       = word0_r;
            res.line_level = 1'b1;
            res.sending    = 1'b1;
          end
          OP_TICK: begin
            if (busy_r) begin
              res.line_level = high_r;
              res.sending    = 1'b1;
              if (ph_inc >= {1'b0, len}) begin
                ph_nxt = '0;
                if (high_r) begin
                  high_nxt = 1'b0;
                end else if (bit_r >= LAST_BIT) begin
                  bit_nxt = '0;
                  if (is_last) begin
                    busy_nxt       = 1'b0;
                    led_nxt        = '0;
                    res.frame_done = 1'b1;
                  end else begin
                    led_nxt  = led_r + 1'b1;
                    high_nxt = 1'b1;
                    word_nxt = rd_vld_r ? rd_data : '0;
                  end
                end else begin
                  bit_nxt  = bit_r + 1'b1;
                  high_nxt = 1'b1;
                  word_nxt = {word_r[ColourW-2:0], 1'b0};
                end
              end else begin
                ph_nxt = ph_inc[TicksW-1:0];
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      led_r       <= '0;
      bit_r       <= '0;
      high_r      <= 1'b0;
      ph_r        <= '0;
      word_r      <= '0;
      word0_r     <= '0;
      vld_r       <= '0;
      rd_vld_r    <= 1'b0;
      one_high_r  <= ONE_HIGH_RST;
      one_low_r   <= ONE_LOW_RST;
      zero_high_r <= ZERO_HIGH_RST;
      zero_low_r  <= ZERO_LOW_RST;
    end else begin
      busy_r   <= busy_nxt;
      led_r    <= led_nxt;
      bit_r    <= bit_nxt;
      high_r   <= high_nxt;
      ph_r     <= ph_nxt;
      word_r   <= word_nxt;
      rd_vld_r <= vld_r[rd_addr];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
        if (wr_addr == '0) begin
          word0_r <= cmd.grb;
        end
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_ONE_HIGH:  one_high_r  <= cfg_data;
          CFG_ONE_LOW:   one_low_r   <= cfg_data;
          CFG_ZERO_HIGH: zero_high_r <= cfg_data;
          CFG_ZERO_LOW:  zero_low_r  <= cfg_data;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the addressable LED serializer. A queue of request
// beats feeds a clocked driver; a clocked monitor compares every result beat
// with a bit-exact predictor of the colour store and the one-wire frame timer.
// Frames run under the default and random pulse lengths, with random
// gaps on both sides and one long result hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import als_pkg::*;

  localparam int LED_N = 4;
  localparam int LED_AW = $clog2(LED_N);
  localparam int MAX_GAP = 40;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int DEFAULT_TICKS = 115;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] req;
    logic [7:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } led_req_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_idx = '0;
  logic [7:0] cfg_data = '0;
  logic       push = 1'b0;
  logic       full;
  logic [1:0] in_req_type = '0;
  logic [7:0] in_led_slot = '0;
  logic [7:0] in_red_level = '0;
  logic [7:0] in_green_level = '0;
  logic [7:0] in_blue_level = '0;
  logic       empty;
  logic       pop = 1'b0;
  logic       out_line_level;
  logic       out_sending;
  logic       out_frame_done;
  logic       out_request_error;

  addressable_led_serializer #(.LED_COUNT(LED_N)) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .in_req_type       (in_req_type),
    .in_led_slot       (in_led_slot),
    .in_red_level      (in_red_level),
    .in_green_level    (in_green_level),
    .in_blue_level     (in_blue_level),
    .empty             (empty),
    .pop               (pop),
    .out_line_level    (out_line_level),
    .out_sending       (out_sending),
    .out_frame_done    (out_frame_done),
    .out_request_error (out_request_error)
  );

  always #4 clk = ~clk;

  // Predictor state.
  logic [ColourW-1:0] colour_mem [LED_N] = '{default: '0};
  logic               busy = 1'b0;
  logic [LED_AW-1:0]  led_pos = '0;
  logic [4:0]         bit_pos = '0;
  logic               hi_phase = 1'b0;
  logic [TicksW-1:0]  phase_cnt = '0;
  logic [TicksW-1:0]  one_high = ONE_HIGH_RST;
  logic [TicksW-1:0]  one_low = ONE_LOW_RST;
  logic [TicksW-1:0]  zero_high = ZERO_HIGH_RST;
  logic [TicksW-1:0]  zero_low = ZERO_LOW_RST;

  led_req_t req_backlog_q [$];
  als_res_t line_expect_q [$];
  led_req_t cur_req;
  als_res_t want_res;
  als_res_t got_res;
  int       send_gap = 0;
  int       pop_stall = 0;
  bit       no_idle = 1'b0;
  bit       hold_done = 1'b0;
  int       beats_seen = 0;
  int       mismatch_cnt = 0;
  int       queued_cnt = 0;
  longint   cycle_cnt = 0;
  longint   cycle_limit = 2000 + LONG_HOLD;

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 96) return $urandom_range(1, 3);
    return $urandom_range(10, MAX_GAP);
  endfunction

  function automatic int pulse_len(input logic [TicksW-1:0] v);
    return (v == 0) ? 1 : int'(v);
  endfunction

  function automatic int frame_length();
    int total;
    logic b;
    total = 0;
    for (int l = 0; l < LED_N; l++) begin
      for (int k = 0; k < ColourW; k++) begin
        b = colour_mem[l][ColourW-1-k];
        total += b ? pulse_len(one_high) + pulse_len(one_low)
                   : pulse_len(zero_high) + pulse_len(zero_low);
      end
    end
    return total;
  endfunction

  task automatic serialize_step(input led_req_t r);
    als_res_t res;
    logic cur_bit;
    logic [TicksW-1:0] len;
    res = '0;
    if (r.req == REQ_TICK) begin
      if (busy) begin
        cur_bit = colour_mem[led_pos][LAST_BIT - bit_pos];
        if (hi_phase) len = cur_bit ? one_high : zero_high;
        else len = cur_bit ? one_low : zero_low;
        res.line_level = hi_phase;
        res.sending = 1'b1;
        phase_cnt = phase_cnt + 1'b1;
        if (phase_cnt >= len) begin
          phase_cnt = '0;
          if (hi_phase) begin
            hi_phase = 1'b0;
          end else if (bit_pos >= LAST_BIT) begin
            bit_pos = '0;
            if (int'(led_pos) + 1 >= LED_N) begin
              busy = 1'b0;
              led_pos = '0;
              res.frame_done = 1'b1;
            end else begin
              led_pos++;
              hi_phase = 1'b1;
            end
          end else begin
            bit_pos++;
            hi_phase = 1'b1;
          end
        end
      end
    end else if (r.req == REQ_UNUSED || busy) begin
      res.line_level = busy & hi_phase;
      res.sending = busy;
      res.request_error = 1'b1;
    end else if (r.req == REQ_WRITE) begin
      if (r.slot >= LED_N) res.request_error = 1'b1;
      else colour_mem[r.slot[LED_AW-1:0]] = {r.green, r.red, r.blue};
    end else begin
      busy = 1'b1;
      led_pos = '0;
      bit_pos = '0;
      hi_phase = 1'b1;
      phase_cnt = '0;
      res.line_level = 1'b1;
      res.sending = 1'b1;
    end
    line_expect_q.push_back(res);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
      send_gap = 0;
    end else begin
      if (push && !full) serialize_step(cur_req);
      if (!push || !full) begin
        if (send_gap > 0) begin
          send_gap--;
          push <= 1'b0;
        end else if (req_backlog_q.size() > 0) begin
          cur_req = req_backlog_q.pop_front();
          in_req_type <= cur_req.req;
          in_led_slot <= cur_req.slot;
          in_red_level <= cur_req.red;
          in_green_level <= cur_req.green;
          in_blue_level <= cur_req.blue;
          push <= 1'b1;
          send_gap = pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  task automatic check_bit(input string field, input logic want_b, input logic got_b);
    if (got_b !== want_b) begin
      if (mismatch_cnt < 50) $error("%s: expected %0b, got %0b", field, want_b, got_b);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beats_seen++;
        if (line_expect_q.size() == 0) begin
          if (mismatch_cnt < 50) $error("result beat arrived with nothing expected");
          mismatch_cnt++;
        end else begin
          want_res = line_expect_q.pop_front();
          got_res = {out_line_level, out_sending, out_frame_done, out_request_error};
          check_bit("line_level", want_res.line_level, got_res.line_level);
          check_bit("sending", want_res.sending, got_res.sending);
          check_bit("frame_done", want_res.frame_done, got_res.frame_done);
          check_bit("request_error", want_res.request_error, got_res.request_error);
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        pop <= 1'b0;
      end else if (!hold_done && beats_seen >= 150) begin
        hold_done = 1'b1;
        pop_stall = LONG_HOLD;
        pop <= 1'b0;
      end else begin
        pop_stall = pick_gap();
        pop <= (pop_stall == 0);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > cycle_limit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic void queue_req(input led_req_t r);
    req_backlog_q.push_back(r);
    queued_cnt++;
    cycle_limit += 2 * (2 * MAX_GAP + 4);
  endfunction

  function automatic led_req_t random_req(input logic [1:0] kind);
    led_req_t r;
    r.req = kind;
    r.slot = 8'($urandom_range(0, 255));
    r.red = 8'($urandom_range(0, 255));
    r.green = 8'($urandom_range(0, 255));
    r.blue = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic void queue_write(input logic [7:0] slot, input logic [7:0] g,
                                      input logic [7:0] r, input logic [7:0] b);
    led_req_t w;
    w = '{req: REQ_WRITE, slot: slot, red: r, green: g, blue: b};
    queue_req(w);
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (req_backlog_q.size() != 0 || push || line_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      CFG_ONE_HIGH:  one_high = val;
      CFG_ONE_LOW:   one_low = val;
      CFG_ZERO_HIGH: zero_high = val;
      CFG_ZERO_LOW:  zero_low = val;
    endcase
  endtask

  task automatic set_timing(input logic [7:0] oh, input logic [7:0] ol,
                            input logic [7:0] zh, input logic [7:0] zl);
    write_reg(CFG_ONE_HIGH, oh);
    write_reg(CFG_ONE_LOW, ol);
    write_reg(CFG_ZERO_HIGH, zh);
    write_reg(CFG_ZERO_LOW, zl);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      queue_req(random_req(REQ_TICK));
    end
    wait_drained();
  endtask

  // The full frame length in ticks bounds what is left of the current frame.
  task automatic send_frame_ticks();
    int n;
    logic [1:0] noise_kind;
    n = frame_length() + $urandom_range(0, 4);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 2))
          0: noise_kind = REQ_WRITE;
          1: noise_kind = REQ_START;
          default: noise_kind = REQ_UNUSED;
        endcase
        queue_req(random_req(noise_kind));
      end
      queue_req(random_req(REQ_TICK));
    end
    wait_drained();
  endtask

  task automatic random_frame(input logic [7:0] oh, input logic [7:0] ol,
                              input logic [7:0] zh, input logic [7:0] zl);
    led_req_t r;
    set_timing(oh, ol, zh, zl);
    no_idle = ($urandom_range(0, 3) == 0);
    repeat ($urandom_range(1, 8)) begin
      r = random_req(REQ_WRITE);
      if ($urandom_range(0, 4) != 0) r.slot = 8'($urandom_range(0, LED_N - 1));
      case ($urandom_range(0, 5))
        0: {r.green, r.red, r.blue} = '0;
        1: {r.green, r.red, r.blue} = '1;
        default: ;
      endcase
      queue_req(r);
    end
    if ($urandom_range(0, 3) == 0) queue_req(random_req(REQ_TICK));
    if ($urandom_range(0, 5) == 0) queue_req(random_req(REQ_UNUSED));
    queue_req(random_req(REQ_START));
    wait_drained();
    send_frame_ticks();
  endtask

  function automatic logic [7:0] rand_len();
    if ($urandom_range(0, 9) < 9) return 8'($urandom_range(0, 1));
    return 8'($urandom_range(2, 3));
  endfunction

  initial begin
    int phase_no;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset pulse lengths, idle requests, range errors and requests while sending.
    queue_req(random_req(REQ_TICK));
    queue_req(random_req(REQ_UNUSED));
    queue_write(8'd255, 8'hFF, 8'hFF, 8'hFF);
    queue_write(8'(LED_N), 8'h12, 8'h34, 8'h56);
    queue_write(8'd0, 8'h7F, 8'hFF, 8'hFF);
    queue_write(8'd1, 8'h00, 8'h00, 8'h00);
    queue_write(8'd2, 8'h80, 8'h01, 8'hA5);
    queue_write(8'(LED_N - 1), 8'h5A, 8'hC3, 8'h0F);
    queue_req(random_req(REQ_START));
    queue_write(8'd1, 8'hFF, 8'hFF, 8'hFF);
    queue_req(random_req(REQ_START));
    queue_req(random_req(REQ_UNUSED));
    wait_drained();

    // A zero bit and a one bit under the reset pulse lengths, then the rest of the frame under short ones.
    send_ticks(DEFAULT_TICKS);
    set_timing(8'd0, 8'd1, 8'd1, 8'd0);
    send_frame_ticks();

    phase_no = 0;
    while (queued_cnt < 700 || phase_no < 2) begin
      random_frame(rand_len(), rand_len(), rand_len(), rand_len());
      phase_no++;
    end

    wait_drained();
    if (mismatch_cnt == 0 && line_expect_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
